[rtl/mpgm_pkg.sv]
// Shared types, constants and helpers for the multi-pattern glob matcher.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mpgm_pkg;

  localparam int DEF_PATTERN_SLOTS = 4;
  localparam int DEF_PATTERN_CHARS = 8;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int ACTIVE_W   = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAT0   = 3'd1;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,  // ordinary name byte, more to follow
    KIND_LAST  = 2'd1,  // final byte of the name
    KIND_EMPTY = 2'd2   // empty name, byte ignored
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;     // already folded to lower case
  } item_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/mpgm_front.sv]
// Front end: accepts name bytes, folds case, classifies them and queues them.
// Depends on mpgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpgm_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [mpgm_pkg::IN_DATA_W-1:0] in_tdata,  // [7:0] name_byte
  input  wire logic                           in_tlast,  // name_end
  input  wire logic                           in_tuser,  // [0] name_empty
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output mpgm_pkg::item_t                     q_item
);
  import mpgm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  item_t            cls;
  logic             push, pop;

  always_comb begin
    cls.ch = fold(in_tdata);
    priority if (in_tuser) begin
      cls.kind = KIND_EMPTY;
    end else if (in_tlast) begin
      cls.kind = KIND_LAST;
    end else begin
      cls.kind = KIND_CHAR;
    end
  end

  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && cnt_r == CNT_W'(QUEUE_DEPTH - 1)) |=> !in_tready)
    else $error("queue filled but still ready");

endmodule

`default_nettype wire

[rtl/mpgm_back.sv]
// Back end: configuration registers, per-pattern NFA position sets, verdict
// and the result register. Depends on mpgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpgm_back #(
  parameter int PATTERN_SLOTS = mpgm_pkg::DEF_PATTERN_SLOTS,
  parameter int PATTERN_CHARS = mpgm_pkg::DEF_PATTERN_CHARS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mpgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mpgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire mpgm_pkg::item_t                 q_item,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mpgm_pkg::OUT_DATA_W-1:0]      out_tdata   // [0] is_match
);
  import mpgm_pkg::*;

  localparam int SET_W = PATTERN_CHARS + 1;
  localparam int PAT_W = PATTERN_CHARS * 8;

  logic [ACTIVE_W-1:0]      act_r;
  logic [PAT_W-1:0]         pat_r [PATTERN_SLOTS];
  logic                     start_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_match_r;
  logic [PATTERN_SLOTS-1:0] slot_hit;
  logic                     pop, verdict, is_result;

  // Follow '*' edges: a reachable star position also reaches the next one.
  function automatic logic [SET_W-1:0] closure(input logic [SET_W-1:0] set_in,
                                               input logic [PATTERN_CHARS-1:0] star_en);
    logic [SET_W-1:0] s;
    s = set_in;
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      if (s[i] && star_en[i]) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        pat_r[s] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_ACTIVE) begin
        act_r <= cfg_wdata[ACTIVE_W-1:0];
      end
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        if (cfg_index == CFG_IDX_PAT0 + CFG_IDX_W'(s)) begin
          pat_r[s] <= cfg_wdata[PAT_W-1:0];
        end
      end
    end
  end

  assign is_result = (q_item.kind != KIND_CHAR);
  assign q_ready   = !is_result || !out_valid_r || out_tready;
  assign pop       = q_valid && q_ready;

  for (genvar g = 0; g < PATTERN_SLOTS; g++) begin : g_slot
    logic [PATTERN_CHARS-1:0] vld, star, any, eq;
    logic [SET_W-1:0]         fin, start_set, base, raw, adv, nxt;
    logic [SET_W-1:0]         set_r;

    always_comb begin
      logic [7:0] pc;
      vld  = '0;
      star = '0;
      any  = '0;
      eq   = '0;
      for (int i = 0; i < PATTERN_CHARS; i++) begin
        pc      = pat_r[g][8*i +: 8];
        star[i] = (pc == CH_STAR);
        any[i]  = (pc == CH_ANY);
        eq[i]   = (fold(pc) == q_item.ch);
        if (i == 0) begin
          vld[i] = (pc != CH_NUL);
        end else begin
          vld[i] = vld[i-1] && (pc != CH_NUL);
        end
      end
    end

    // one-hot mark at the pattern length
    assign fin       = {vld, 1'b1} & ~{1'b0, vld};
    assign start_set = closure(SET_W'(1), vld & star);
    assign base      = start_r ? start_set : set_r;

    always_comb begin
      raw = '0;
      for (int i = 0; i < PATTERN_CHARS; i++) begin
        if (base[i] && vld[i]) begin
          if (star[i]) begin
            raw[i] = 1'b1;
          end else if (any[i] || eq[i]) begin
            raw[i+1] = 1'b1;
          end
        end
      end
    end

    assign adv = closure(raw, vld & star);
    assign nxt = (q_item.kind == KIND_EMPTY) ? start_set : adv;
    assign slot_hit[g] = (act_r > ACTIVE_W'(g)) && (!vld[0] || (|(nxt & fin)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        set_r <= '0;
      end else if (pop) begin
        set_r <= nxt;
      end
    end
  end

  assign verdict = (act_r == '0) || (|slot_hit);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && is_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      start_r     <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        start_r <= is_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_result) begin
      out_match_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 1)'(0), out_match_r};

  a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !is_result && !out_valid_r) |=> !out_valid_r)
    else $error("result raised by a plain name byte");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_result) |=> start_r)
    else $error("name start not armed after a result");

  a_no_patterns: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_result && act_r == '0) |=> (out_valid_r && out_match_r))
    else $error("no active patterns must always match");

endmodule

`default_nettype wire

[rtl/multi_pattern_glob_matcher_core.sv]
// Top level of the multi-pattern glob matcher: front queue plus NFA back end.
// Depends on mpgm_pkg, mpgm_front and mpgm_back.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata=name_byte, tlast=name_end, tuser=name_empty
//  out_    | out | out_tvalid/out_tready| tdata[0]=is_match
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// One name byte per cycle while in_tready is high; a name's result passes through the
// queue entry, then the result register, before out_tvalid rises.
// The back end updates the NFA position sets of every pattern slot in parallel.
// Reset clears the queue count, config and position sets; no clearing pass is needed.
// A two-entry queue and the result register let input and output stall independently.
`timescale 1ns / 1ps
`default_nettype none

module multi_pattern_glob_matcher_core #(
  parameter int PATTERN_SLOTS = mpgm_pkg::DEF_PATTERN_SLOTS,
  parameter int PATTERN_CHARS = mpgm_pkg::DEF_PATTERN_CHARS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mpgm_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] name_byte
  input  wire logic                            in_tlast,   // name_end
  input  wire logic                            in_tuser,   // [0] name_empty
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mpgm_pkg::OUT_DATA_W-1:0]      out_tdata,  // [0] is_match, rest zero
  input  wire logic                            cfg_we,
  input  wire logic [mpgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mpgm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mpgm_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  mpgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  mpgm_back #(
    .PATTERN_SLOTS (PATTERN_SLOTS),
    .PATTERN_CHARS (PATTERN_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[tb/tb_glob_pkg.sv]
// Scoreboard for the multi-pattern glob matcher testbench: a bit-parallel
// position-set predictor plus the queue of expected match flags. Needs mpgm_pkg.
`timescale 1ns / 1ps

package tb_glob_pkg;
  import mpgm_pkg::*;

  localparam int SLOTS = DEF_PATTERN_SLOTS;
  localparam int CHARS = DEF_PATTERN_CHARS;
  localparam int NUM_CFG_REGS = 1 + SLOTS;

  class glob_scoreboard;
    logic [CFG_DATA_W-1:0] pattern_reg [SLOTS];
    logic [ACTIVE_W-1:0]   active_count;
    logic [CHARS:0]        reach [SLOTS];
    bit                    name_start;
    bit                    match_expected [$];
    int                    errors;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        pattern_reg[s] = '0;
        reach[s] = '0;
      end
      active_count = '0;
      name_start = 1'b1;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IDX_ACTIVE) begin
        active_count = val[ACTIVE_W-1:0];
      end else if (idx >= CFG_IDX_PAT0 && idx - CFG_IDX_PAT0 < SLOTS) begin
        pattern_reg[idx - CFG_IDX_PAT0] = val;
      end
    endfunction

    function int pattern_len(int s);
      int n;
      n = 0;
      while (n < CHARS && pattern_reg[s][8*n +: 8] != CH_NUL) n++;
      return n;
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c | 8'h20;
      return c;
    endfunction

    // a reachable '*' also makes the position behind it reachable
    function logic [CHARS:0] close_stars(int s, logic [CHARS:0] set);
      int len;
      len = pattern_len(s);
      for (int i = 0; i < len; i++) begin
        if (set[i] && pattern_reg[s][8*i +: 8] == CH_STAR) set[i+1] = 1'b1;
      end
      return set;
    endfunction

    function logic [CHARS:0] consume(int s, logic [CHARS:0] set, logic [7:0] c);
      int             len;
      logic [CHARS:0] next;
      logic [7:0]     p;
      len = pattern_len(s);
      next = '0;
      for (int i = 0; i < len; i++) begin
        if (set[i]) begin
          p = pattern_reg[s][8*i +: 8];
          if (p == CH_STAR) next[i] = 1'b1;
          else if (p == CH_ANY || lower(p) == lower(c)) next[i+1] = 1'b1;
        end
      end
      return close_stars(s, next);
    endfunction

    function bit name_matches();
      int used;
      int len;
      used = (active_count > SLOTS) ? SLOTS : active_count;
      if (used == 0) return 1'b1;
      for (int s = 0; s < used; s++) begin
        len = pattern_len(s);
        if (len == 0 || reach[s][len]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic [7:0] c, bit last, bit empty);
      if (empty) begin
        // drops any partial name and judges the empty one
        for (int s = 0; s < SLOTS; s++) reach[s] = close_stars(s, 1);
        name_start = 1'b1;
        match_expected.push_back(name_matches());
        return;
      end
      if (name_start) begin
        for (int s = 0; s < SLOTS; s++) reach[s] = close_stars(s, 1);
        name_start = 1'b0;
      end
      for (int s = 0; s < SLOTS; s++) reach[s] = consume(s, reach[s], c);
      if (last) begin
        name_start = 1'b1;
        match_expected.push_back(name_matches());
      end
    endfunction

    function int pending();
      return match_expected.size();
    endfunction

    function void check_match(logic [OUT_DATA_W-1:0] data);
      bit want;
      if (match_expected.size() == 0) begin
        $error("is_match: expected no transfer, got %0d", data[0]);
        errors++;
        return;
      end
      want = match_expected.pop_front();
      if (data[0] !== want) begin
        $error("is_match: expected %0d, got %0d", want, data[0]);
        errors++;
      end
      if (data[OUT_DATA_W-1:1] !== '0) begin
        $error("out_tdata padding: expected 0, got %0h", data[OUT_DATA_W-1:1]);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb_multi_pattern_glob_matcher_core.sv]
// Top-level testbench for multi_pattern_glob_matcher_core: directed and random
// filename streams under random configs and stalls. Needs mpgm_pkg, tb_glob_pkg.
`timescale 1ns / 1ps

module tb_multi_pattern_glob_matcher_core;
  import mpgm_pkg::*;
  import tb_glob_pkg::*;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 400;
  localparam int STUCK_LIMIT    = 1000;
  localparam int SETTLE_CYCLES  = 10;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [7:0] name_byte
  logic                  in_tlast = 1'b0;  // name_end
  logic                  in_tuser = 1'b0;  // [0] name_empty
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [0] is_match
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  glob_scoreboard sb = new();
  logic [7:0]     name_buf [$];
  int             items_sent = 0;
  int             stuck_cycles = 0;
  bit             tx_burst = 1'b0;
  bit             rx_burst = 1'b0;

  multi_pattern_glob_matcher_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // handshakes are sampled at the falling edge, where all inputs and outputs are settled
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int         stall;
    bit         got;
    logic [7:0] data;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_tvalid;
        data = out_tdata;
        @(posedge clk);
      end while (!got);
      sb.check_match(data);
    end
  end

  task automatic send_item(logic [7:0] c, bit last, bit empty);
    int gap;
    bit ok;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    in_tuser <= empty;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_input(c, last, empty);
    items_sent++;
  endtask

  // an empty buffer goes out as an empty-name transfer
  task automatic send_name();
    if (name_buf.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      foreach (name_buf[i]) send_item(name_buf[i], i == name_buf.size() - 1, 1'b0);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // trailing bytes without a result may still be in flight after the last result
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high across a burst of writes; caller lowers it
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [7:0] small_char();
    case ($urandom_range(0, 5))
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "B";
      4: return "x";
      default: return ".";
    endcase
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_pattern();
    logic [CFG_DATA_W-1:0] p;
    int                    r;
    int                    len;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return {$urandom, $urandom};
    if (r < 15) return '1;
    // random garbage behind the terminator must be ignored
    p = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    len = $urandom_range(1, CHARS);
    for (int i = 0; i < CHARS; i++) begin
      if (i == len) begin
        p[8*i +: 8] = CH_NUL;
      end else if (i < len) begin
        r = $urandom_range(0, 99);
        if (r < 25) p[8*i +: 8] = CH_STAR;
        else if (r < 45) p[8*i +: 8] = CH_ANY;
        else if (r < 90) p[8*i +: 8] = small_char();
        else p[8*i +: 8] = 8'($urandom_range(1, 255));
      end
    end
    return p;
  endfunction

  task automatic random_config(bit write_all);
    logic [CFG_IDX_W-1:0] spare;
    if ($urandom_range(0, 9) < 7) begin
      cfg_write(CFG_IDX_ACTIVE, CFG_DATA_W'($urandom_range(1, SLOTS)));
    end else begin
      cfg_write(CFG_IDX_ACTIVE, CFG_DATA_W'($urandom_range(0, 7)));
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (write_all || $urandom_range(0, 9) < 7) begin
        cfg_write(CFG_IDX_PAT0 + CFG_IDX_W'(s), random_pattern());
      end
    end
    if ($urandom_range(0, 6) == 0) begin
      spare = CFG_IDX_W'(NUM_CFG_REGS + $urandom_range(0, 2));
      cfg_write(spare, {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
  endtask

  // a name that follows pattern s, then maybe one edit to break it
  task automatic name_from_pattern(int s);
    logic [7:0] p;
    int         pos;
    name_buf.delete();
    for (int i = 0; i < sb.pattern_len(s); i++) begin
      p = sb.pattern_reg[s][8*i +: 8];
      if (p == CH_STAR) repeat ($urandom_range(0, 3)) name_buf.push_back(small_char());
      else if (p == CH_ANY)
        name_buf.push_back($urandom_range(0, 9) < 7 ? small_char() : 8'($urandom_range(0, 255)));
      else name_buf.push_back(flip_case(p));
    end
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, name_buf.size());
      if (pos == name_buf.size()) name_buf.push_back(small_char());
      else if ($urandom_range(0, 1)) name_buf[pos] = small_char();
      else name_buf.delete(pos);
    end
  endtask

  initial begin
    int r;
    int names;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // everything matches while no pattern is active
    send_item(8'hFF, 1'b0, 1'b1);
    send_item("q", 1'b1, 1'b0);
    settle();

    cfg_write(CFG_IDX_ACTIVE, CFG_DATA_W'(3));
    cfg_write(CFG_IDX_PAT0, {32'h0, CH_ANY, "B", CH_STAR, "a"});
    cfg_write(CFG_IDX_PAT0 + 3'd1, '1);                   // eight chars, no terminator
    cfg_write(CFG_IDX_PAT0 + 3'd2, {48'h0, "[", "Z"});    // '[' must not fold to '{'
    cfg_write(CFG_IDX_PAT0 + 3'd3, 64'hFFFF_FFFF_FFFF_FF00); // empty, junk after the terminator
    cfg_we <= 1'b0;
    name_buf = '{"A", "z", "z", "b", "Q"};
    send_name();
    name_buf = '{"a", "b"};
    send_name();
    name_buf.delete();
    repeat (CHARS) name_buf.push_back(8'hFF);
    send_name();
    name_buf = '{"a", 8'h00, "b", 8'h00};                 // zero bytes under '*' and '?'
    send_name();
    name_buf = '{"z", "{"};
    send_name();
    settle();

    // count above the slot number: the empty fourth pattern now takes part
    cfg_write(CFG_IDX_ACTIVE, CFG_DATA_W'(7));
    cfg_write(CFG_IDX_W'(NUM_CFG_REGS), '1);
    cfg_we <= 1'b0;
    send_item("x", 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);                         // aborts the partial name

    r = 1;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      settle();
      random_config(r == 1);
      r = 0;
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      names = $urandom_range(4, 12);
      repeat (names) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          name_from_pattern($urandom_range(0, SLOTS - 1));
          send_name();
        end else if (r < 72) begin
          name_buf.delete();
          repeat ($urandom_range(1, 6)) name_buf.push_back(small_char());
          send_name();
        end else if (r < 82) begin
          name_buf.delete();
          repeat ($urandom_range(1, 5)) name_buf.push_back(8'($urandom_range(0, 255)));
          send_name();
        end else if (r < 90) begin
          name_buf.delete();
          send_name();
        end else begin
          repeat ($urandom_range(1, 3)) send_item(small_char(), 1'b0, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        if ($urandom_range(0, 14) == 0) drain();
      end
      // leave a name open across the next register change
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_item(small_char(), 1'b0, 1'b0);
      r = 0;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mpgm_pkg.sv
rtl/mpgm_front.sv
rtl/mpgm_back.sv
rtl/multi_pattern_glob_matcher_core.sv
tb/tb_glob_pkg.sv
tb/tb_multi_pattern_glob_matcher_core.sv
